// File: rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg: shared widths, types and the divider step for the HSV converter
// Holds the lane payload carried down the divider chain and the one-bit
// restoring division step that every cell applies.
// ----------------------------------------------------------------------------
package hsv_pkg;

  localparam int COMP_W     = 8;              // one color component
  localparam int QUO_W      = 13;             // quotient bits per lane
  localparam int NUM_W      = COMP_W + QUO_W; // numerator width
  localparam int HUE_W      = 13;
  localparam int PCT_W      = 11;
  localparam int CELL_COUNT = QUO_W;          // one quotient bit per cell
  localparam int S_W        = 11;             // sextant position, up to 6*255

  // Percent lanes divide 4x the numerator; the two extra quotient bits drop.
  localparam int PCT_DROP   = QUO_W - PCT_W;

  localparam logic [HUE_W-1:0] HUE_RANGE = HUE_W'(5760);
  localparam logic [COMP_W-1:0] FULL_SCALE = COMP_W'(255);

  typedef struct packed {
    logic [COMP_W-1:0] rem;   // partial remainder, always below div
    logic [QUO_W-1:0]  low;   // numerator bits not yet brought down
    logic [QUO_W-1:0]  quo;   // quotient bits so far
    logic [COMP_W-1:0] div;   // divisor
  } div_lane_t;

  typedef struct packed {
    div_lane_t hue;
    div_lane_t sat;
    div_lane_t val;
  } div_bundle_t;

  // Load a lane: top bits seed the remainder (quotient fits QUO_W bits,
  // so the seed is already below the divisor).
  function automatic div_lane_t lane_load(logic [NUM_W-1:0] num,
                                          logic [COMP_W-1:0] dvs);
    div_lane_t l;
    l.rem = num[NUM_W-1:QUO_W];
    l.low = num[QUO_W-1:0];
    l.quo = '0;
    l.div = dvs;
    return l;
  endfunction

  // One restoring division step.
  function automatic div_lane_t div_step(div_lane_t l);
    logic [COMP_W:0] trial;
    logic [COMP_W:0] diff;
    div_lane_t       n;
    trial = {l.rem, l.low[QUO_W-1]};
    diff  = trial - {1'b0, l.div};
    n     = l;
    n.low = {l.low[QUO_W-2:0], 1'b0};
    if (trial >= {1'b0, l.div}) begin
      n.rem = diff[COMP_W-1:0];
      n.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      n.rem = trial[COMP_W-1:0];
      n.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// File: rtl/hsv_pix_if.sv
// ----------------------------------------------------------------------------
// hsv_pix_if: pixel request channel
// Valid/ready channel carrying one 8-bit RGB pixel.
// ----------------------------------------------------------------------------
interface hsv_pix_if import hsv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/hsv_res_if.sv
// ----------------------------------------------------------------------------
// hsv_res_if: HSV result channel
// Valid/ready channel carrying hue, saturation and value.
// ----------------------------------------------------------------------------
interface hsv_res_if import hsv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [PCT_W-1:0] saturation;
  logic [PCT_W-1:0] value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

// File: rtl/hsv_prep.sv
// ----------------------------------------------------------------------------
// hsv_prep: front stage of the converter
// Finds max, min, chroma and sextant position, and loads the three
// divider lanes with their scaled numerators and divisors.
// ----------------------------------------------------------------------------
module hsv_prep import hsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hsv_pix_if.sink     pix,
  output logic        out_valid,
  output div_bundle_t out_data,
  input  logic        out_ready
);

  logic              valid;
  div_bundle_t       data;
  div_bundle_t       data_next;

  logic [COMP_W-1:0] r, g, b;
  logic [COMP_W-1:0] mx, mn, c;
  logic [S_W-1:0]    s;
  logic [S_W-1:0]    c_w;
  logic [NUM_W-1:0]  hue_num, sat_num, val_num;
  logic [NUM_W-1:0]  c_n, mx_n, s_n;
  logic              r_max, g_ge_b;

  always_comb begin
    r      = pix.red;
    g      = pix.green;
    b      = pix.blue;
    r_max  = (r >= g) && (r >= b);
    g_ge_b = (g >= b);
    mx     = r_max ? r : (g_ge_b ? g : b);
    if ((r <= g) && (r <= b)) begin
      mn = r;
    end else if (g <= b) begin
      mn = g;
    end else begin
      mn = b;
    end
    c   = mx - mn;
    c_w = S_W'(c);
    // sextant position times chroma, kept nonnegative (mod 2^S_W arithmetic)
    if (r_max) begin
      s = g_ge_b ? (S_W'(g) - S_W'(b)) : (S_W'(6) * c_w - (S_W'(b) - S_W'(g)));
    end else if (g_ge_b) begin
      s = (c_w << 1) + S_W'(b) - S_W'(r);
    end else begin
      s = (c_w << 2) + S_W'(r) - S_W'(g);
    end
    s_n  = NUM_W'(s);
    c_n  = NUM_W'(c);
    mx_n = NUM_W'(mx);
    // 960*s, 6400*c, 6400*max
    hue_num = (s_n << 10) - (s_n << 6);
    sat_num = (c_n << 12) + (c_n << 11) + (c_n << 8);
    val_num = (mx_n << 12) + (mx_n << 11) + (mx_n << 8);
    if (c == '0) begin
      // achromatic: force zero quotients on hue and saturation
      data_next.hue = lane_load('0, COMP_W'(1));
      data_next.sat = lane_load('0, COMP_W'(1));
    end else begin
      data_next.hue = lane_load(hue_num, c);
      data_next.sat = lane_load(sat_num, mx);
    end
    data_next.val = lane_load(val_num, FULL_SCALE);
  end

  assign pix.ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pix.ready) begin
      valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.ready && pix.valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// File: rtl/hsv_div_cell.sv
// ----------------------------------------------------------------------------
// hsv_div_cell: one cell of the divider chain
// Produces one quotient bit on each of the three lanes and hands the
// lanes to the next cell.
// ----------------------------------------------------------------------------
module hsv_div_cell import hsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  div_bundle_t in_data,
  output logic        in_ready,
  output logic        out_valid,
  output div_bundle_t out_data,
  input  logic        out_ready
);

  logic        valid;
  div_bundle_t data;

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.hue <= div_step(in_data.hue);
      data.sat <= div_step(in_data.sat);
      data.val <= div_step(in_data.val);
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// File: rtl/rgb_to_hsv_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert: 8-bit RGB to HSV, one pixel per clock while res.ready is high
// Hue in 1/16 degree, saturation and value in 1/16 percent, all floored.
// A front stage forms the scaled numerators, then a chain of identical
// cells runs three restoring divisions side by side, one bit per cell.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                          | request
//  --------+-----+---------------------------------+-----------------------
//  pix     | in  | red, green, blue  (8b each)     | one pixel
//  res     | out | hue (13b), saturation, value (11b each) | one HSV result
//
//  - 1 front stage + 13 divider cells (one quotient bit per cell on every
//    lane). One request per clock while res.ready is held high.
//  - The depth of the chain is set by the 13-bit quotient; saturation and
//    value divide 4x their numerator and drop the two low quotient bits.
//  - rst is synchronous and clears only the stage valid bits.
//  - Stalls: each stage takes new data when empty or when its successor
//    moves, so bubbles collapse and res.ready reaches pix.ready
//    combinationally; up to 14 requests can be held during a stall.
//
module rgb_to_hsv_convert import hsv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  hsv_pix_if.sink   pix,
  hsv_res_if.source res
);

  // Stage 0 is the front stage output; stage k is cell k's output.
  logic        stage_valid [CELL_COUNT+1];
  logic        stage_ready [CELL_COUNT+1];
  div_bundle_t stage_data  [CELL_COUNT+1];

  hsv_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix),
    .out_valid (stage_valid[0]),
    .out_data  (stage_data[0]),
    .out_ready (stage_ready[0])
  );

  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    hsv_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_data   (stage_data[k]),
      .in_ready  (stage_ready[k]),
      .out_valid (stage_valid[k+1]),
      .out_data  (stage_data[k+1]),
      .out_ready (stage_ready[k+1])
    );
  end

  // Last cell's registers are the output register.
  assign stage_ready[CELL_COUNT] = res.ready;
  assign res.valid      = stage_valid[CELL_COUNT];
  assign res.hue        = stage_data[CELL_COUNT].hue.quo;
  assign res.saturation = stage_data[CELL_COUNT].sat.quo[QUO_W-1:PCT_DROP];
  assign res.value      = stage_data[CELL_COUNT].val.quo[QUO_W-1:PCT_DROP];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // an accepted pixel lands in the front stage
  a_front_load: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> stage_valid[0])
    else $error("accepted pixel not captured by front stage");

  // hue stays inside one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.hue < HUE_RANGE))
    else $error("hue out of range");

  // a chromatic hue implies nonzero saturation and value
  a_chroma_fields: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.hue != '0)) |-> ((res.saturation != '0) && (res.value != '0)))
    else $error("hue set on an achromatic result");

  // restoring division keeps the remainder below the divisor on every lane
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    stage_valid[CELL_COUNT] |->
      ((stage_data[CELL_COUNT].hue.rem < stage_data[CELL_COUNT].hue.div) &&
       (stage_data[CELL_COUNT].sat.rem < stage_data[CELL_COUNT].sat.div) &&
       (stage_data[CELL_COUNT].val.rem < stage_data[CELL_COUNT].val.div)))
    else $error("divider remainder not below divisor");

endmodule

// File: bench/rgb_to_hsv_convert_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_tb: self-checking bench for the RGB to HSV converter
// Sends a short table of known pixels, then random pixels under three
// handshake profiles. Every result is compared field by field, in request
// order, against a hand-typed answer or an in-bench integer model.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_tb;
  import hsv_pkg::*;

  // One HSV result as the bench sees it.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] val;
  } hsv_t;

  // Directed row: a pixel, plus a hand-typed answer where one is obvious.
  typedef struct packed {
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
    logic              known;
    hsv_t              want;
  } pix_row_t;

  localparam int ROWS      = 21;
  localparam int RAND_ITEMS = 617;   // per handshake profile (one fewer in the last), three profiles
  localparam int TAIL_CYC  = 30;     // pipeline is 14 deep, leave margin

  logic clk;
  logic rst;

  hsv_pix_if pix ();
  hsv_res_if res ();

  rgb_to_hsv_convert dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res)
  );

  hsv_t     hsv_pending[$];   // expected results, oldest first
  pix_row_t dir_tbl[ROWS];
  int       fail_count = 0;
  int       tx_idle_pct = 0;  // chance the sender inserts a gap before a request
  int       rx_idle_pct = 0;  // chance the receiver holds ready low on a cycle

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop; the slowest profile needs well under a tenth of this.
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Integer model of the conversion. max/min/chroma pick the sextant, then
  // every quotient is floored. Achromatic pixels give hue and sat of zero,
  // black also gives value zero.
  function automatic hsv_t hsv_expect(logic [COMP_W-1:0] r_in, logic [COMP_W-1:0] g_in,
                                      logic [COMP_W-1:0] b_in);
    int unsigned r, g, b, hi, lo, span, pos;
    hsv_t        o;
    r  = r_in;
    g  = g_in;
    b  = b_in;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    span = hi - lo;
    o = '0;
    if (span != 0) begin
      // red sextant wraps past 360 degrees when blue beats green
      if (hi == r)      pos = (g >= b) ? (g - b) : (6 * span - (b - g));
      else if (hi == g) pos = 2 * span + b - r;
      else              pos = 4 * span + r - g;
      o.hue = HUE_W'((960 * pos) / span);
      o.sat = PCT_W'((1600 * span) / hi);
    end
    o.val = PCT_W'((1600 * hi) / 255);
    return o;
  endfunction

  // Present one request at the falling edge, optionally after a random gap,
  // and hold it until accepted. Returns at the falling edge after acceptance
  // so back-to-back requests keep valid high without a glitch.
  task automatic send_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                            logic [COMP_W-1:0] b, logic known, hsv_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
    hsv_pending.push_back(known ? want : hsv_expect(r, g, b));
    @(negedge clk);
  endtask

  // Sender holds off until every outstanding result is back.
  task automatic wait_drained();
    pix.valid <= 1'b0;
    @(negedge clk);
    while (hsv_pending.size() != 0) @(negedge clk);
  endtask

  // Random pixels with extra weight on greys and two-way ties, where the
  // sextant choice and the achromatic path are easiest to get wrong.
  task automatic send_random(int count);
    logic [COMP_W-1:0] r, g, b;
    int                mode;
    for (int i = 0; i < count; i++) begin
      r = COMP_W'($urandom);
      g = COMP_W'($urandom);
      b = COMP_W'($urandom);
      mode = $urandom_range(7);
      if (mode == 0) begin
        g = r;
        b = r;
      end else if (mode == 1) begin
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      send_pixel(r, g, b, 1'b0, '0);
    end
  endtask

  // Receiver: ready is redrawn at every falling edge.
  always @(negedge clk) begin
    res.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    hsv_t exp_r;
    if (!rst && res.valid && res.ready) begin
      if (hsv_pending.size() == 0) begin
        $error("unexpected result hue=%0d saturation=%0d value=%0d",
               res.hue, res.saturation, res.value);
        fail_count++;
      end else begin
        exp_r = hsv_pending.pop_front();
        if (res.hue !== exp_r.hue) begin
          $error("hue: expected %0d, got %0d", exp_r.hue, res.hue);
          fail_count++;
        end
        if (res.saturation !== exp_r.sat) begin
          $error("saturation: expected %0d, got %0d", exp_r.sat, res.saturation);
          fail_count++;
        end
        if (res.value !== exp_r.val) begin
          $error("value: expected %0d, got %0d", exp_r.val, res.value);
          fail_count++;
        end
      end
    end
  end

  // Directed rows. Hand-typed answers for black, white, mid grey and the six
  // primaries/secondaries; the rest (hue wrap, one-LSB chroma, ties, small
  // values) go through the model.
  initial begin
    dir_tbl[0]  = '{8'd0,   8'd0,   8'd0,   1'b1, '{13'd0,    11'd0,    11'd0}};
    dir_tbl[1]  = '{8'd255, 8'd255, 8'd255, 1'b1, '{13'd0,    11'd0,    11'd1600}};
    dir_tbl[2]  = '{8'd128, 8'd128, 8'd128, 1'b1, '{13'd0,    11'd0,    11'd803}};
    dir_tbl[3]  = '{8'd255, 8'd0,   8'd0,   1'b1, '{13'd0,    11'd1600, 11'd1600}};
    dir_tbl[4]  = '{8'd0,   8'd255, 8'd0,   1'b1, '{13'd1920, 11'd1600, 11'd1600}};
    dir_tbl[5]  = '{8'd0,   8'd0,   8'd255, 1'b1, '{13'd3840, 11'd1600, 11'd1600}};
    dir_tbl[6]  = '{8'd255, 8'd255, 8'd0,   1'b1, '{13'd960,  11'd1600, 11'd1600}};
    dir_tbl[7]  = '{8'd0,   8'd255, 8'd255, 1'b1, '{13'd2880, 11'd1600, 11'd1600}};
    dir_tbl[8]  = '{8'd255, 8'd0,   8'd255, 1'b1, '{13'd4800, 11'd1600, 11'd1600}};
    dir_tbl[9]  = '{8'd255, 8'd0,   8'd1,   1'b0, '0};  // hue just below 360
    dir_tbl[10] = '{8'd1,   8'd0,   8'd0,   1'b0, '0};
    dir_tbl[11] = '{8'd0,   8'd0,   8'd1,   1'b0, '0};
    dir_tbl[12] = '{8'd1,   8'd1,   8'd1,   1'b0, '0};  // dimmest grey
    dir_tbl[13] = '{8'd255, 8'd254, 8'd254, 1'b0, '0};  // chroma of one
    dir_tbl[14] = '{8'd254, 8'd255, 8'd255, 1'b0, '0};
    dir_tbl[15] = '{8'd170, 8'd85,  8'd255, 1'b0, '0};
    dir_tbl[16] = '{8'd85,  8'd170, 8'd90,  1'b0, '0};
    dir_tbl[17] = '{8'd200, 8'd200, 8'd100, 1'b0, '0};  // red/green tie at max
    dir_tbl[18] = '{8'd100, 8'd200, 8'd200, 1'b0, '0};  // green/blue tie at max
    dir_tbl[19] = '{8'd200, 8'd100, 8'd200, 1'b0, '0};  // red/blue tie at max
    dir_tbl[20] = '{8'd1,   8'd255, 8'd0,   1'b0, '0};
  end

  // Main sequence.
  initial begin
    rst        = 1'b1;
    pix.valid  = 1'b0;
    pix.red    = '0;
    pix.green  = '0;
    pix.blue   = '0;
    res.ready  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table, light idling on both sides
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    for (int i = 0; i < ROWS; i++)
      send_pixel(dir_tbl[i].r, dir_tbl[i].g, dir_tbl[i].b, dir_tbl[i].known,
                 dir_tbl[i].want);
    wait_drained();

    // sparse sender, congested receiver: pipeline fills and stalls
    tx_idle_pct = 21;
    rx_idle_pct = 80;
    send_random(RAND_ITEMS);
    wait_drained();

    // bursty receiver, slow sender: bubbles through the chain
    tx_idle_pct = 80;
    rx_idle_pct = 21;
    send_random(RAND_ITEMS);
    wait_drained();

    // full rate both ways
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(RAND_ITEMS - 1);
    wait_drained();

    // let any stray result show up before calling it
    repeat (TAIL_CYC) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
